[sv/ngp_pkg.sv]
// Package for the NMEA GGA position parser: character codes, field widths,
// conversion constants and the event types passed from the parser to the converter.
// No dependencies.
package ngp_pkg;

  // Character codes.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] SEP_RESET  = 8'd44;

  // Widths of the stored field parts.
  localparam int unsigned DEG_W  = 11;  // degrees, at most 1310
  localparam int unsigned MINS_W = 7;   // integer minutes, at most 99
  localparam int unsigned FRAC_W = 24;  // scaled fraction, below 10**7
  localparam int unsigned CNT_W  = 3;   // fraction digits kept, up to 7
  localparam int unsigned X_W    = 30;  // minutes times 1e7, below 1e9
  localparam int unsigned Q_W    = 24;  // minutes times 1e7 over 60
  localparam int unsigned SUM_W  = 35;  // degrees times 1e7 plus the above

  // Integer digit accumulator saturates at 131071 = 1310 * 100 + 71.
  localparam logic [13:0] DEG_SAT = 14'd1310;
  localparam logic [6:0]  LO_SAT  = 7'd71;

  localparam logic [29:0] LAT_MAX = 30'd900000000;
  localparam logic [30:0] LON_MAX = 31'd1800000000;
  localparam logic [23:0] E7      = 24'd10000000;

  // ceil(2**32 / 15); exact quotient for dividends below 2**28.
  localparam logic [31:0] RECIP15 = 32'h1111_1112;

  // Header text on line positions 1 to 5.
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd1:    ch = 8'h47;  // G
      3'd2:    ch = 8'h50;  // P
      3'd3:    ch = 8'h47;  // G
      3'd4:    ch = 8'h47;  // G
      3'd5:    ch = 8'h41;  // A
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [23:0] pow10(input logic [2:0] k);
    logic [23:0] p;
    case (k)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  typedef struct packed {
    logic fin_lat;  // the latitude field is finished by this event
    logic fin_lon;  // the longitude field is finished by this event
    logic ok;       // the finished field is well formed
    logic eol;      // end of line: held values are cleared afterwards
    logic emit;     // end of a matching line: a result goes out
  } ctl_t;

  typedef struct packed {
    ctl_t                    ctl;
    logic [DEG_W-1:0]        deg;
    logic [MINS_W-1:0]       mins;
    logic [FRAC_W-1:0]       frac;
  } evt_t;

endpackage

[sv/ngp_parse.sv]
// Character parser of the NMEA GGA position parser: line, header and field
// tracking plus digit accumulation, one byte per cycle unless stalled.
// Emits field and end-of-line events. Depends on ngp_pkg.
module ngp_parse #(
  parameter int unsigned MAX_FRACTION_DIGITS = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   rx_byte_i,
  input  logic [7:0]   sep_i,
  output logic         ev_valid_o,
  output ngp_pkg::evt_t ev_o,
  input  logic         ev_ready_i
);
  import ngp_pkg::*;

  localparam logic [CNT_W:0]   FD_NUM  = (CNT_W+1)'(MAX_FRACTION_DIGITS);
  localparam logic [CNT_W-1:0] FD_LAST = CNT_W'(MAX_FRACTION_DIGITS - 1);

  logic [6:0]        pos_q, pos_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [3:0]        fld_q, fld_d;
  logic [DEG_W-1:0]  hi_q, hi_d;
  logic [3:0]        tens_q, tens_d;
  logic [3:0]        units_q, units_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pt_q, pt_d;
  logic              dig_q, dig_d;
  logic              bad_q, bad_d;
  logic              ev_valid_q, ev_valid_d;
  evt_t              ev_q, ev_d;

  logic        accept;
  logic        is_space, is_nl, is_point, is_digit, is_sep;
  logic        in_hdr, in_body, emit;
  logic [3:0]  dgt;
  logic [13:0] hi_ext;
  logic [6:0]  lo_ext;
  logic        int_sat;
  logic        fld_ok, fld_lat, fld_lon;
  logic [FRAC_W-1:0] frac_add;

  assign in_stall_o = ev_valid_q && !ev_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_space = rx_byte_i == CHAR_SPACE;
  assign is_nl    = rx_byte_i == CHAR_NL;
  assign is_sep   = rx_byte_i == sep_i;
  assign is_point = rx_byte_i == CHAR_POINT;
  assign is_digit = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
  assign dgt      = rx_byte_i[3:0];

  assign in_hdr  = (pos_q >= 7'd1) && (pos_q <= 7'd5);
  assign in_body = pos_q >= 7'd7;
  assign emit    = hdr_ok_q && (pos_q >= 7'd6);

  // Integer digits are kept as degrees plus the last two decimal digits, which
  // makes the split at the point free.
  assign hi_ext  = 14'(hi_q) * 14'd10 + 14'(tens_q);
  assign lo_ext  = 7'(units_q) * 7'd10 + 7'(dgt);
  assign int_sat = (hi_ext > DEG_SAT) || ((hi_ext == DEG_SAT) && (lo_ext > LO_SAT));

  // Fraction digits are weighted on arrival so no padding is needed later.
  assign frac_add = FRAC_W'(dgt) * pow10(FD_LAST - cnt_q);

  assign fld_ok  = dig_q && pt_q && !bad_q;
  assign fld_lat = fld_q == 4'd1;
  assign fld_lon = fld_q == 4'd3;

  always_comb begin
    pos_d    = pos_q;
    hdr_ok_d = hdr_ok_q;
    fld_d    = fld_q;
    hi_d     = hi_q;
    tens_d   = tens_q;
    units_d  = units_q;
    frac_d   = frac_q;
    cnt_d    = cnt_q;
    pt_d     = pt_q;
    dig_d    = dig_q;
    bad_d    = bad_q;

    ev_d.ctl.fin_lat = emit && in_body && fld_lat;
    ev_d.ctl.fin_lon = emit && in_body && fld_lon;
    ev_d.ctl.ok      = fld_ok;
    ev_d.ctl.eol     = is_nl;
    ev_d.ctl.emit    = emit;
    ev_d.deg         = hi_q;
    ev_d.mins        = MINS_W'(tens_q) * MINS_W'(10) + MINS_W'(units_q);
    ev_d.frac        = frac_q;
    ev_valid_d       = ev_valid_q && !ev_ready_i;

    if (accept && !is_space) begin
      if (is_nl) begin
        ev_valid_d = 1'b1;
        pos_d      = '0;
        hdr_ok_d   = 1'b1;
        fld_d      = '0;
        hi_d       = '0;
        tens_d     = '0;
        units_d    = '0;
        frac_d     = '0;
        cnt_d      = '0;
        pt_d       = 1'b0;
        dig_d      = 1'b0;
        bad_d      = 1'b0;
      end else begin
        if (in_hdr && (rx_byte_i != hdr_char(pos_q[2:0]))) begin
          hdr_ok_d = 1'b0;
        end
        if (in_body) begin
          if (is_sep) begin
            ev_d.ctl.fin_lat = fld_lat;
            ev_d.ctl.fin_lon = fld_lon;
            ev_d.ctl.eol     = 1'b0;
            ev_d.ctl.emit    = 1'b0;
            if (fld_lat || fld_lon) begin
              ev_valid_d = 1'b1;
            end
            if (fld_q != 4'd15) begin
              fld_d = fld_q + 4'd1;
            end
            hi_d    = '0;
            tens_d  = '0;
            units_d = '0;
            frac_d  = '0;
            cnt_d   = '0;
            pt_d    = 1'b0;
            dig_d   = 1'b0;
            bad_d   = 1'b0;
          end else if (is_point) begin
            bad_d = bad_q || pt_q;
            pt_d  = 1'b1;
          end else if (is_digit) begin
            dig_d = 1'b1;
            if (!pt_q) begin
              if (int_sat) begin
                hi_d    = DEG_W'(DEG_SAT);
                tens_d  = 4'd7;
                units_d = 4'd1;
              end else begin
                hi_d    = hi_ext[DEG_W-1:0];
                tens_d  = units_q;
                units_d = dgt;
              end
            end else if ({1'b0, cnt_q} < FD_NUM) begin
              frac_d = frac_q + frac_add;
              cnt_d  = cnt_q + CNT_W'(1);
            end
          end else begin
            bad_d = 1'b1;
          end
        end
        if (pos_q != 7'd127) begin
          pos_d = pos_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_ok_q   <= 1'b1;
      fld_q      <= '0;
      hi_q       <= '0;
      tens_q     <= '0;
      units_q    <= '0;
      frac_q     <= '0;
      cnt_q      <= '0;
      pt_q       <= 1'b0;
      dig_q      <= 1'b0;
      bad_q      <= 1'b0;
      ev_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      hdr_ok_q   <= hdr_ok_d;
      fld_q      <= fld_d;
      hi_q       <= hi_d;
      tens_q     <= tens_d;
      units_q    <= units_d;
      frac_q     <= frac_d;
      cnt_q      <= cnt_d;
      pt_q       <= pt_d;
      dig_q      <= dig_d;
      bad_q      <= bad_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_space) begin
      ev_q <= ev_d;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule

[sv/ngp_conv.sv]
// Converter of the NMEA GGA position parser: turns field events into 1e-7 degree
// values in a short pipeline, holds them per line and drives the result register.
// Depends on ngp_pkg.
module ngp_conv #(
  parameter int unsigned MAX_FRACTION_DIGITS = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ev_valid_i,
  input  ngp_pkg::evt_t ev_i,
  output logic          ev_ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [29:0]   lat_e7_o,
  output logic [30:0]   lon_e7_o,
  output logic          lat_ok_o,
  output logic          lon_ok_o
);
  import ngp_pkg::*;

  localparam logic [X_W-1:0] FRAC_SCALE = X_W'(10 ** (7 - MAX_FRACTION_DIGITS));

  // Stage 1: minutes scaled by 1e7.
  logic              c1_valid_q;
  ctl_t              c1_ctl_q;
  logic [DEG_W-1:0]  c1_deg_q;
  logic [X_W-1:0]    c1_x_q;
  // Stage 2: quotient by 60 and degrees scaled by 1e7.
  logic              c2_valid_q;
  ctl_t              c2_ctl_q;
  logic [Q_W-1:0]    c2_quot_q;
  logic [SUM_W-1:0]  c2_deg_q;
  // Held values of the current line.
  logic [29:0]       lat_q, lat_d;
  logic [30:0]       lon_q, lon_d;
  logic              lat_v_q, lat_v_d;
  logic              lon_v_q, lon_v_d;
  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [29:0]       out_lat_q;
  logic [30:0]       out_lon_q;
  logic              out_lat_ok_q, out_lon_ok_q;

  logic              out_free, fin_ready, fin_take, c2_load, c1_load;
  logic [X_W-1:0]    x_d;
  logic [63:0]       prod;
  logic [SUM_W-1:0]  sum;
  logic [29:0]       lat_sat, lat_cur;
  logic [30:0]       lon_sat, lon_cur;
  logic              lat_v_cur, lon_v_cur;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_ready  = !c2_ctl_q.emit || out_free;
  assign fin_take   = c2_valid_q && fin_ready;
  assign c2_load    = !c2_valid_q || fin_ready;
  assign c1_load    = !c1_valid_q || c2_load;
  assign ev_ready_o = c1_load;

  assign x_d  = X_W'(ev_i.mins) * X_W'(E7) + X_W'(ev_i.frac) * FRAC_SCALE;
  // Divide by 60 as a shift by two and a reciprocal multiply for 15.
  assign prod = 64'(c1_x_q[X_W-1:2]) * 64'(RECIP15);
  assign sum  = c2_deg_q + SUM_W'(c2_quot_q);

  assign lat_sat = (sum > SUM_W'(LAT_MAX)) ? LAT_MAX : sum[29:0];
  assign lon_sat = (sum > SUM_W'(LON_MAX)) ? LON_MAX : sum[30:0];

  always_comb begin
    lat_cur   = lat_q;
    lon_cur   = lon_q;
    lat_v_cur = lat_v_q;
    lon_v_cur = lon_v_q;
    if (c2_ctl_q.fin_lat) begin
      lat_cur   = c2_ctl_q.ok ? lat_sat : '0;
      lat_v_cur = c2_ctl_q.ok;
    end
    if (c2_ctl_q.fin_lon) begin
      lon_cur   = c2_ctl_q.ok ? lon_sat : '0;
      lon_v_cur = c2_ctl_q.ok;
    end

    lat_d       = lat_q;
    lon_d       = lon_q;
    lat_v_d     = lat_v_q;
    lon_v_d     = lon_v_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fin_take) begin
      if (c2_ctl_q.eol) begin
        lat_d       = '0;
        lon_d       = '0;
        lat_v_d     = 1'b0;
        lon_v_d     = 1'b0;
        out_valid_d = c2_ctl_q.emit || out_valid_d;
      end else begin
        lat_d   = lat_cur;
        lon_d   = lon_cur;
        lat_v_d = lat_v_cur;
        lon_v_d = lon_v_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q  <= 1'b0;
      c2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lat_q       <= '0;
      lon_q       <= '0;
      lat_v_q     <= 1'b0;
      lon_v_q     <= 1'b0;
    end else begin
      if (c1_load) begin
        c1_valid_q <= ev_valid_i;
      end
      if (c2_load) begin
        c2_valid_q <= c1_valid_q;
      end
      out_valid_q <= out_valid_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      lat_v_q     <= lat_v_d;
      lon_v_q     <= lon_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c1_load && ev_valid_i) begin
      c1_ctl_q <= ev_i.ctl;
      c1_deg_q <= ev_i.deg;
      c1_x_q   <= x_d;
    end
    if (c2_load && c1_valid_q) begin
      c2_ctl_q  <= c1_ctl_q;
      c2_quot_q <= prod[32+Q_W-1:32];
      c2_deg_q  <= SUM_W'(c1_deg_q) * SUM_W'(E7);
    end
    if (fin_take && c2_ctl_q.emit) begin
      out_lat_q    <= lat_cur;
      out_lon_q    <= lon_cur;
      out_lat_ok_q <= lat_v_cur;
      out_lon_ok_q <= lon_v_cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lat_e7_o    = out_lat_q;
  assign lon_e7_o    = out_lon_q;
  assign lat_ok_o    = out_lat_ok_q;
  assign lon_ok_o    = out_lon_ok_q;

endmodule

[sv/nmea_gga_position_parser.sv]
// Top level of the NMEA GGA position parser: separator register, character
// parser and conversion pipeline. Depends on ngp_pkg, ngp_parse and ngp_conv.
//
// Usage:
//   The receive channel (in_valid_i, in_stall_o, rx_byte_i) takes one ASCII
//   character per transfer, up to one transfer every clock cycle. Spaces are
//   dropped. A newline ends a sentence; when the line read GPGGA on
//   characters 1 to 5, one result transfer follows on the result channel
//   (out_valid_o, out_stall_i, lat_e7_o, lon_e7_o, lat_ok_o, lon_ok_o).
//   Latitude is field 1 (ddmm.mmmmm) and longitude field 3 (dddmm.mmmmm),
//   converted to degrees in units of 1e-7 and saturated; a malformed or
//   missing field gives a zero value with its flag low.
//   A result passes the parser's event register and both conversion stages
//   to out_valid_o. Throughput is one character per cycle unless stalled,
//   set by the parser's per-byte state update; the conversion runs behind
//   it in a two-stage pipeline with constant multipliers in each stage.
//   While the receiver stalls a result, the block keeps taking characters
//   until its pipeline stages are full, then raises in_stall_o.
//   The configuration channel (cfg_valid_i, cfg_ready_o,
//   cfg_field_separator_i) writes the field separator byte and is always
//   ready. Reset sets the separator to a comma and empties all line state;
//   no clearing pass is needed.
module nmea_gga_position_parser #(
  parameter int unsigned MAX_FRACTION_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [29:0] lat_e7_o,
  output logic [30:0] lon_e7_o,
  output logic        lat_ok_o,
  output logic        lon_ok_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_field_separator_i
);
  import ngp_pkg::*;

  logic [7:0] sep_q;
  logic       ev_valid;
  logic       ev_ready;
  evt_t       ev;

  // The separator register takes every write and has no datapath interlock.
  // The user must make configuration changes only while idle; it is not enforced.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sep_q <= cfg_field_separator_i;
    end
  end

  // The parser tracks position, header and fields and sends one event when
  // field 1 or field 3 ends and one at every newline.
  ngp_parse #(
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .sep_i      (sep_q),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_ready_i (ev_ready)
  );

  // The converter scales each finished field, holds the values of the line
  // and presents them at the end of a matching line.
  ngp_conv #(
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_i        (ev),
    .ev_ready_o  (ev_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lat_e7_o    (lat_e7_o),
    .lon_e7_o    (lon_e7_o),
    .lat_ok_o    (lat_ok_o),
    .lon_ok_o    (lon_ok_o)
  );

endmodule

[sv/ngp_checker.sv]
// Port checker for the NMEA GGA position parser and its bind to the top level.
// Depends on nmea_gga_position_parser.
module ngp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [29:0] lat_e7_i,
  input logic [30:0] lon_e7_i,
  input logic        lat_ok_i,
  input logic        lon_ok_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its values.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      $stable(lat_e7_i) && $stable(lon_e7_i) && $stable(lat_ok_i) && $stable(lon_ok_i))
    else $error("result changed while stalled");

  // An invalid latitude reads as zero and a valid one stays in range.
  a_lat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (lat_ok_i || lat_e7_i == 30'd0) && (lat_e7_i <= 30'd900000000))
    else $error("latitude value inconsistent with its flag or range");

  // An invalid longitude reads as zero and a valid one stays in range.
  a_lon_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (lon_ok_i || lon_e7_i == 31'd0) && (lon_e7_i <= 31'd1800000000))
    else $error("longitude value inconsistent with its flag or range");

endmodule

bind nmea_gga_position_parser ngp_checker u_ngp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .lat_e7_i    (lat_e7_o),
  .lon_e7_i    (lon_e7_o),
  .lat_ok_i    (lat_ok_o),
  .lon_ok_i    (lon_ok_o)
);

[tb/sv/nmea_gga_fix_checker.sv]
// Checker for the NMEA GGA position parser: watches the receive, result and
// separator channels, predicts each position fix and compares it field by field.
// Depends on ngp_pkg for character codes and the saturation limits.
`timescale 1ns / 1ps

module nmea_gga_fix_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [29:0] lat_e7_i,
  input  logic [30:0] lon_e7_i,
  input  logic        lat_ok_i,
  input  logic        lon_ok_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_sep_i,
  output int          mismatch_count_o,
  output int          fixes_pending_o,
  output int          fixes_predicted_o,
  output int          fixes_seen_o
);
  import ngp_pkg::*;

  localparam int FRAC_DIGITS = 5;
  localparam int WHOLE_SAT = 131071;
  localparam int MAX_COLUMN = 127;
  localparam int MAX_FIELD = 15;
  localparam int LAT_FIELD = 1;
  localparam int LON_FIELD = 3;
  localparam int MAX_REPORTS = 10;
  localparam logic [39:0] GGA_TAG = "GPGGA";

  typedef struct packed {
    logic [29:0] lat;
    logic [30:0] lon;
    logic        lat_ok;
    logic        lon_ok;
  } gga_fix_t;

  gga_fix_t expected_fixes[$];

  // Line and field state of the parser as predicted.
  logic [7:0]  sep_q;
  logic [6:0]  column;
  logic        tag_ok;
  logic [3:0]  field_idx;
  logic [16:0] whole_acc;
  logic [16:0] frac_acc;
  logic [2:0]  frac_n;
  logic        dot_seen;
  logic        num_seen;
  logic        field_broken;
  logic [29:0] lat_hold;
  logic [30:0] lon_hold;
  logic        lat_good;
  logic        lon_good;

  function automatic longint unsigned ten_to(input int k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Degrees in 1e-7 units: ddd from the leading digits, mm.mmmmm over 60.
  function automatic longint unsigned degrees_e7(input longint unsigned limit);
    longint unsigned scale, whole, deg, mins, v;
    scale = ten_to(FRAC_DIGITS);
    whole = whole_acc;
    deg = whole / 100;
    mins = (whole % 100) * scale + longint'(frac_acc) * ten_to(FRAC_DIGITS - int'(frac_n));
    v = deg * 64'd10000000 + (mins * 64'd10000000) / (64'd60 * scale);
    return (v > limit) ? limit : v;
  endfunction

  function automatic void clear_field();
    whole_acc = '0;
    frac_acc = '0;
    frac_n = '0;
    dot_seen = 1'b0;
    num_seen = 1'b0;
    field_broken = 1'b0;
  endfunction

  function automatic void clear_line();
    column = '0;
    tag_ok = 1'b1;
    field_idx = '0;
    clear_field();
    lat_hold = '0;
    lon_hold = '0;
    lat_good = 1'b0;
    lon_good = 1'b0;
  endfunction

  function automatic void close_field();
    logic ok;
    ok = num_seen && dot_seen && !field_broken;
    if (field_idx == LAT_FIELD) begin
      lat_good = ok;
      lat_hold = ok ? 30'(degrees_e7(longint'(LAT_MAX))) : '0;
    end else if (field_idx == LON_FIELD) begin
      lon_good = ok;
      lon_hold = ok ? 31'(degrees_e7(longint'(LON_MAX))) : '0;
    end
  endfunction

  function automatic void take_symbol(input logic [7:0] c);
    int acc;
    if (c == CHAR_POINT) begin
      if (dot_seen) field_broken = 1'b1;
      dot_seen = 1'b1;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      num_seen = 1'b1;
      if (!dot_seen) begin
        acc = int'(whole_acc) * 10 + int'(c - CHAR_ZERO);
        whole_acc = 17'((acc > WHOLE_SAT) ? WHOLE_SAT : acc);
      end else if (frac_n < FRAC_DIGITS) begin
        acc = int'(frac_acc) * 10 + int'(c - CHAR_ZERO);
        frac_acc = 17'(acc);
        frac_n = frac_n + 3'd1;
      end
    end else begin
      field_broken = 1'b1;
    end
  endfunction

  function automatic void predict_char(input logic [7:0] c);
    if (c == CHAR_SPACE) return;
    if (c == CHAR_NL) begin
      if (tag_ok && column >= 6) begin
        if (column >= 7) close_field();
        expected_fixes.push_back('{lat: lat_hold, lon: lon_hold,
                                   lat_ok: lat_good, lon_ok: lon_good});
        fixes_pending_o++;
        fixes_predicted_o++;
      end
      clear_line();
      return;
    end
    if (column >= 1 && column <= 5) begin
      if (c != GGA_TAG[8 * (5 - int'(column)) +: 8]) tag_ok = 1'b0;
    end else if (column >= 7) begin
      if (c == sep_q) begin
        close_field();
        if (field_idx < MAX_FIELD) field_idx = field_idx + 4'd1;
        clear_field();
      end else begin
        take_symbol(c);
      end
    end
    if (column < MAX_COLUMN) column = column + 7'd1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : fix_compare
    gga_fix_t got, want;
    if (!rst_ni) begin
      sep_q = SEP_RESET;
      clear_line();
      expected_fixes.delete();
      mismatch_count_o = 0;
      fixes_pending_o = 0;
      fixes_predicted_o = 0;
      fixes_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{lat: lat_e7_i, lon: lon_e7_i, lat_ok: lat_ok_i, lon_ok: lon_ok_i};
        fixes_seen_o++;
        if (expected_fixes.size() == 0) begin
          if (mismatch_count_o < MAX_REPORTS)
            $display("%0t: unexpected fix lat %0d ok %0b lon %0d ok %0b", $time,
                     got.lat, got.lat_ok, got.lon, got.lon_ok);
          mismatch_count_o++;
        end else begin
          want = expected_fixes.pop_front();
          fixes_pending_o--;
          if (got !== want) begin
            if (mismatch_count_o < MAX_REPORTS)
              $display({"%0t: fix mismatch, expected lat %0d ok %0b lon %0d ok %0b,",
                        " got lat %0d ok %0b lon %0d ok %0b"},
                       $time, want.lat, want.lat_ok, want.lon, want.lon_ok,
                       got.lat, got.lat_ok, got.lon, got.lon_ok);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) sep_q = cfg_sep_i;
      if (in_valid_i && !in_stall_i) predict_char(rx_byte_i);
    end
  end

endmodule

[tb/sv/nmea_gga_position_parser_tb.sv]
// Testbench top for the NMEA GGA position parser: clock, reset, sentence
// stimulus, result sink and verdict. Depends on ngp_pkg, the parser RTL and
// nmea_gga_fix_checker.
`timescale 1ns / 1ps

module nmea_gga_position_parser_tb;
  import ngp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  // The long receiver hold-off that backs results up into the input side.
  localparam int HOLD_CYCLES = 1500;
  // A line without a result may still be in flight after the last predicted fix
  // has left, so the drain waits on past it.
  localparam int DRAIN_CYCLES = 8;
  localparam int CHAR_TARGET = 1450;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [29:0] lat_e7;
  logic [30:0] lon_e7;
  logic        lat_ok;
  logic        lon_ok;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_sep;

  int mismatches, fixes_pending, fixes_predicted, fixes_seen;

  // Stimulus bookkeeping.
  logic [7:0] line_buf[$];
  logic [7:0] cur_sep;
  logic       space_noise;
  logic       tx_quiet;
  logic       hold_off_go;
  int         chars_sent, lines_sent, sep_writes, cycle_count;

  always #4 clk = ~clk;

  nmea_gga_position_parser u_top (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .rx_byte_i            (rx_byte),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .lat_e7_o             (lat_e7),
    .lon_e7_o             (lon_e7),
    .lat_ok_o             (lat_ok),
    .lon_ok_o             (lon_ok),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_field_separator_i(cfg_sep)
  );

  nmea_gga_fix_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .lat_e7_i         (lat_e7),
    .lon_e7_i         (lon_e7),
    .lat_ok_i         (lat_ok),
    .lon_ok_i         (lon_ok),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_sep_i        (cfg_sep),
    .mismatch_count_o (mismatches),
    .fixes_pending_o  (fixes_pending),
    .fixes_predicted_o(fixes_predicted),
    .fixes_seen_o     (fixes_seen)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d fixes outstanding.", cycle_count,
               fixes_pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sink. Stall stretches of random length are drawn per result, with
  // occasional runs of results taken back to back. Once the stimulus asks for
  // it, the sink holds off for a long stretch so that the pipeline fills and
  // the parser has to stall its input.
  initial begin : result_sink
    int  wait_n;
    int  calm_left;
    logic held;
    out_stall = 1'b0;
    calm_left = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_go && !held) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (calm_left > 0) begin
        calm_left--;
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(0, 7);
        if ($urandom_range(0, 5) == 0) calm_left = $urandom_range(4, 16);
      end
      if (wait_n > 0) begin
        out_stall = 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Any byte but the two that carry a meaning of their own.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_SPACE || b == CHAR_NL);
    return b;
  endfunction

  // Appends one character; in random lines a dropped space sometimes precedes it.
  task automatic put_ch(input logic [7:0] c);
    if (space_noise && $urandom_range(0, 19) == 0) line_buf.push_back(CHAR_SPACE);
    line_buf.push_back(c);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) put_ch(8'(CHAR_ZERO + $urandom_range(0, 9)));
  endtask

  // One coordinate field in ddmm.mmmmm (or dddmm.mmmmm) form, now and then
  // at its extremes, overlong, malformed or plain garbage.
  task automatic put_coord(input int max_deg);
    int    style;
    string junk_set;
    style = $urandom_range(0, 99);
    junk_set = "0123456789.-+NSEW*";
    if (style < 65) begin
      if (max_deg > 90)
        put_text($sformatf("%03d%02d", $urandom_range(0, max_deg), $urandom_range(0, 59)));
      else
        put_text($sformatf("%02d%02d", $urandom_range(0, max_deg), $urandom_range(0, 59)));
      put_ch(CHAR_POINT);
      put_digits($urandom_range(0, 8));
    end else if (style < 75) begin
      case ($urandom_range(0, 3))
        0: put_text(max_deg > 90 ? "18000.00000" : "9000.00000");
        1: put_text("0000.00000");
        2: put_text(max_deg > 90 ? "18059.9999999" : "9059.9999999");
        default: put_text("0.0");
      endcase
    end else if (style < 85) begin
      // Long integer parts saturate the digit accumulator.
      put_digits($urandom_range(0, 10));
      put_ch(CHAR_POINT);
      put_digits($urandom_range(0, 9));
    end else if (style < 95) begin
      case ($urandom_range(0, 4))
        0: ;
        1: put_ch(CHAR_POINT);
        2: put_digits($urandom_range(1, 6));
        3: begin
          put_digits($urandom_range(0, 4));
          put_ch(CHAR_POINT);
          put_digits($urandom_range(0, 3));
          put_ch(CHAR_POINT);
          put_digits($urandom_range(0, 3));
        end
        default: begin
          put_digits($urandom_range(0, 4));
          put_ch(plain_byte());
          put_digits($urandom_range(0, 2));
          put_ch(CHAR_POINT);
          put_digits($urandom_range(0, 5));
        end
      endcase
    end else begin
      repeat ($urandom_range(0, 10)) put_ch(junk_set[$urandom_range(0, junk_set.len() - 1)]);
    end
  endtask

  // A GGA-like sentence with random content. A broken one has a corrupted
  // header, a stray byte somewhere, or is cut short before its newline.
  task automatic compose_sentence(input logic broken);
    logic [7:0] fs;
    string      tag;
    int         flaw, n_extra, keep;
    // A space or newline separator cannot appear inside a line; fall back
    // to a comma so the text keeps its shape.
    fs = (cur_sep == CHAR_SPACE || cur_sep == CHAR_NL) ? SEP_RESET : cur_sep;
    line_buf.delete();
    tag = "GPGGA";
    flaw = broken ? $urandom_range(0, 2) : 3;
    if (flaw == 0) tag[$urandom_range(0, 4)] = plain_byte();
    put_ch(($urandom_range(0, 3) == 0) ? plain_byte() : 8'h24);
    put_text(tag);
    put_ch(($urandom_range(0, 3) == 0) ? plain_byte() : fs);
    if ($urandom_range(0, 1) == 1) begin
      put_digits(6);
      put_ch(CHAR_POINT);
      put_digits(2);
    end
    put_ch(fs);
    put_coord(90);
    put_ch(fs);
    put_text(($urandom_range(0, 1) == 1) ? "N" : "S");
    put_ch(fs);
    put_coord(180);
    put_ch(fs);
    put_text(($urandom_range(0, 1) == 1) ? "E" : "W");
    // Trailing fields; a few sentences run past the position and field
    // counter limits.
    n_extra = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 6);
    repeat (n_extra) begin
      put_ch(fs);
      put_digits($urandom_range(0, 5));
    end
    if (flaw == 1) line_buf[$urandom_range(0, line_buf.size() - 1)] = plain_byte();
    if (flaw == 2) begin
      keep = $urandom_range(0, line_buf.size());
      while (line_buf.size() > keep) void'(line_buf.pop_back());
    end
    line_buf.push_back(CHAR_NL);
  endtask

  // Noise: any byte at all, newlines and spaces included.
  task automatic compose_noise();
    line_buf.delete();
    repeat ($urandom_range(0, 60)) line_buf.push_back(8'($urandom_range(0, 255)));
    line_buf.push_back(CHAR_NL);
  endtask

  // One character transfer, after a random gap unless the line is sent quiet.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    rx_byte = c;
    do @(posedge clk); while (in_stall);
    if (c != CHAR_SPACE) chars_sent++;
  endtask

  task automatic send_line();
    tx_quiet = ($urandom_range(0, 3) == 0);
    foreach (line_buf[i]) send_char(line_buf[i]);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    put_text(s);
    send_line();
  endtask

  task automatic send_random_line();
    int pick;
    space_noise = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 75) compose_sentence(1'b0);
    else if (pick < 88) compose_sentence(1'b1);
    else compose_noise();
    send_line();
  endtask

  // Waits until every predicted fix has come out, plus the pipeline depth.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (fixes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The separator register is only written with the parser idle.
  task automatic set_separator(input logic [7:0] v);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_sep = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_sep = v;
    sep_writes++;
  endtask

  task automatic run_random(input int budget);
    int start;
    start = chars_sent;
    while (chars_sent - start < budget) send_random_line();
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_sep = '0;
    cur_sep = SEP_RESET;
    space_noise = 1'b0;
    tx_quiet = 1'b0;
    hold_off_go = 1'b0;
    chars_sent = 0;
    lines_sent = 0;
    sep_writes = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_separator(SEP_RESET);

    // Directed lines: a full sentence, both saturation limits, empty and
    // malformed fields, short and mismatching headers, lines that end inside
    // the latitude or longitude field, dropped spaces and an overlong line.
    send_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n");
    send_text("$GPGGA,,9000.00000,S,18000.00000,W\n");
    send_text("$GPGGA,,9959.9999999,N,99999999.99999,E\n");
    send_text("$GPGGA,,0000.00000,N,0.0,E\n");
    send_text("$GPGGA,,,N,,E\n");
    send_text("$GPGGA,,12.3.4,N,12a4.5,E\n");
    send_text("$GPGGA,,1234,N,.,E\n");
    send_text("$GPGGA\n");
    send_text("$GPGG\n");
    send_text("$GPGGX,,1.0,N,2.0,E\n");
    send_text("$GPGGA,,4916.45\n");
    send_text("$GPGGA,,4916.45,N,12311.1234\n");
    send_text("$ GP GGA , ,49 16.45, N,1 2311.12,W\n");
    send_text("\n");
    line_buf.delete();
    put_text("$GPGGA,,1.1,N,2.2,E");
    repeat (24) put_text(",123456789");
    put_ch(CHAR_NL);
    send_line();
    // Characters 0 and 6 are never looked at, whatever they hold.
    line_buf.delete();
    put_ch(8'h00);
    put_text("GPGGA");
    put_ch(8'hFF);
    put_text(",4916.5,N,1.5,E\n");
    send_line();

    // Random phases, one per separator setting. The first phase also
    // triggers the long hold-off in the result sink.
    hold_off_go = 1'b1;
    run_random(250);
    set_separator("*");
    run_random(60);
    set_separator(CHAR_POINT);
    run_random(60);
    set_separator("7");
    run_random(60);
    set_separator(8'h00);
    run_random(60);
    set_separator(8'hFF);
    run_random(60);
    set_separator(CHAR_SPACE);
    run_random(40);
    set_separator(CHAR_NL);
    run_random(40);
    set_separator(SEP_RESET);
    while (chars_sent < CHAR_TARGET) send_random_line();

    wait_drained();
    $display("Sent %0d characters in %0d lines across %0d separator settings.",
             chars_sent, lines_sent, sep_writes);
    $display("Predicted %0d position fixes and received %0d.", fixes_predicted, fixes_seen);
    if (mismatches == 0 && fixes_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
